[rtl/core/laser_line_row_peak_finder_top_assert.svh]
// Assertion macros used by the checker file of the laser line row peak finder.
`ifndef LASER_LINE_ROW_PEAK_FINDER_TOP_ASSERT_SVH
`define LASER_LINE_ROW_PEAK_FINDER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define LLPF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llpf assertion failed");

// Next-cycle implication, disabled while rst is high.
`define LLPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("llpf assertion failed");

// Condition that must hold in the cycle after a reset cycle.
`define LLPF_ASSERT_AFTER_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("llpf reset assertion failed");

`endif

[rtl/core/llpf_pkg.sv]
// Shared types and constants of the laser line row peak finder.
package llpf_pkg;

  localparam int MAX_DIM = 4096;

  localparam int COL_W  = 12;
  localparam int DIM_W  = 13;
  localparam int CNT_W  = 13;
  localparam int SUM_W  = 22;
  localparam int GREY_SHIFT = 14;

  localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIM);

  localparam logic [13:0] W_RED   = 14'd4899;
  localparam logic [13:0] W_GREEN = 14'd9617;
  localparam logic [13:0] W_BLUE  = 14'd1868;
  localparam logic [SUM_W-1:0] GREY_ROUND = 22'd8192;

  localparam logic [CNT_W-1:0] COUNT_MAX  = 13'd8191;
  localparam logic [COL_W-1:0] COLUMN_MAX = 12'd4095;

  typedef enum logic [2:0] {
    REG_LEVEL_THRESHOLD = 3'd0,
    REG_FRAME_WIDTH     = 3'd1,
    REG_FRAME_HEIGHT    = 3'd2,
    REG_COL_START       = 3'd3,
    REG_COL_END         = 3'd4,
    REG_ROW_START       = 3'd5,
    REG_ROW_END         = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [7:0]       level_threshold;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [COL_W-1:0] col_start;
    logic [DIM_W-1:0] col_end;
    logic [COL_W-1:0] row_start;
    logic [DIM_W-1:0] row_end;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] row_index;
    logic [COL_W-1:0] peak_column;
    logic [7:0]       peak_level;
    logic             frame_done;
  } result_t;

endpackage

[rtl/core/llpf_grey.sv]
// Channel thresholding and weighted lightness of one pixel.
module llpf_grey (
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] level_threshold,
  output logic [7:0] grey
);
  import llpf_pkg::*;

  logic [7:0]       r_keep;
  logic [7:0]       g_keep;
  logic [7:0]       b_keep;
  logic [SUM_W-1:0] sum;

  assign r_keep = (red   > level_threshold) ? red   : 8'd0;
  assign g_keep = (green > level_threshold) ? green : 8'd0;
  assign b_keep = (blue  > level_threshold) ? blue  : 8'd0;

  // The weights add up to 2^14, so the sum never exceeds 22 bits.
  assign sum = SUM_W'(r_keep) * SUM_W'(W_RED)
             + SUM_W'(g_keep) * SUM_W'(W_GREEN)
             + SUM_W'(b_keep) * SUM_W'(W_BLUE)
             + GREY_ROUND;

  assign grey = sum[GREY_SHIFT +: 8];

endmodule

[rtl/core/llpf_tracker.sv]
// Raster counters, window peak tracking and row result formation.
module llpf_tracker (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     grey,
  input  logic           frame_start,
  input  llpf_pkg::cfg_t cfg,
  output logic           has_result,
  output llpf_pkg::result_t result
);
  import llpf_pkg::*;

  logic [COL_W-1:0] column_counter, column_counter_next;
  logic [COL_W-1:0] row_counter, row_counter_next;
  logic [7:0]       best_level, best_level_next;
  logic [COL_W-1:0] best_column, best_column_next;
  logic [CNT_W-1:0] equal_count, equal_count_next;
  logic             found, found_next;

  logic [COL_W-1:0] col, row;
  logic [DIM_W-1:0] fw, fh, last;
  logic [DIM_W-1:0] col_ext, row_ext, pc_wide;
  logic             row_end_hit;

  always_comb begin
    // A frame start mark clears the counters before this pixel is used.
    col = frame_start ? '0 : column_counter;
    row = frame_start ? '0 : row_counter;
    found_next       = frame_start ? 1'b0 : found;
    best_level_next  = frame_start ? 8'd0 : best_level;
    best_column_next = frame_start ? '0 : best_column;
    equal_count_next = frame_start ? '0 : equal_count;
    col_ext = {1'b0, col};
    row_ext = {1'b0, row};

    fw = (cfg.frame_width == '0) ? DIM_W'(1) :
         (cfg.frame_width > MAX_DIM_C) ? MAX_DIM_C : cfg.frame_width;
    fh = (cfg.frame_height == '0) ? DIM_W'(1) :
         (cfg.frame_height > MAX_DIM_C) ? MAX_DIM_C : cfg.frame_height;

    if (col == cfg.col_start && col_ext < cfg.col_end) begin
      found_next       = 1'b1;
      best_column_next = col;
      best_level_next  = grey;
      equal_count_next = CNT_W'(1);
    end else if (found_next && col > cfg.col_start && col_ext < cfg.col_end) begin
      if (grey == best_level_next) begin
        if (equal_count_next < COUNT_MAX) begin
          equal_count_next = equal_count_next + CNT_W'(1);
        end
      end else if (grey > best_level_next) begin
        best_column_next = col;
        best_level_next  = grey;
        equal_count_next = '0;
      end
    end

    row_end_hit = col_ext >= (fw - DIM_W'(1));
    last        = (cfg.row_end < fh) ? cfg.row_end : fh;
    has_result  = row_end_hit && (row >= cfg.row_start) && (row_ext < last);

    pc_wide = {1'b0, best_column_next} + {1'b0, equal_count_next[CNT_W-1:1]};
    result.row_index  = row;
    result.frame_done = (row_ext == last - DIM_W'(1));
    if (found_next) begin
      result.peak_column = (pc_wide > {1'b0, COLUMN_MAX}) ? COLUMN_MAX
                                                          : pc_wide[COL_W-1:0];
      result.peak_level  = best_level_next;
    end else begin
      result.peak_column = cfg.col_start;
      result.peak_level  = 8'd0;
    end

    if (row_end_hit) begin
      found_next          = 1'b0;
      best_level_next     = 8'd0;
      best_column_next    = '0;
      equal_count_next    = '0;
      column_counter_next = '0;
      row_counter_next    = (row_ext >= fh - DIM_W'(1)) ? '0 : row + COL_W'(1);
    end else begin
      column_counter_next = col + COL_W'(1);
      row_counter_next    = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
      best_level     <= 8'd0;
      best_column    <= '0;
      equal_count    <= '0;
      found          <= 1'b0;
    end else if (step) begin
      column_counter <= column_counter_next;
      row_counter    <= row_counter_next;
      best_level     <= best_level_next;
      best_column    <= best_column_next;
      equal_count    <= equal_count_next;
      found          <= found_next;
    end
  end

endmodule

[rtl/core/laser_line_row_peak_finder_top.sv]
// Top level of the laser line row peak finder: configuration, pipeline and output register.
//
// Pixels enter on the input channel (in_valid/in_ready) in raster order, one
// transaction per pixel, with frame_start set on the first pixel of a frame.
// The block counts columns and rows itself. For each row inside the row window
// it sends one transaction on the output channel (out_valid/out_ready) carrying
// the row index, the peak column, the peak lightness and frame_done on the
// last reported row. Other pixels produce no output transaction.
// The pipeline has two registers: a lightness stage after the input and the
// result register, written as a row's last pixel leaves the lightness stage.
// With out_ready held high the block accepts one pixel every cycle; the
// tracking state in the second stage is updated once per pixel and sets that
// rate. While the receiver stalls, the result stays on the output and one more
// pixel can still enter the lightness stage; after that in_ready drops. The user
// must write registers through cfg_write/cfg_index/cfg_data only while the block
// is idle; the block does not enforce this. Index seven is ignored. A synchronous
// rst restores the register reset values, clears the counters and empties the pipeline.
module laser_line_row_peak_finder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  blue,
  input  logic [7:0]  green,
  input  logic [7:0]  red,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] row_index,
  output logic [11:0] peak_column,
  output logic [7:0]  peak_level,
  output logic        frame_done
);
  import llpf_pkg::*;

  cfg_t       cfg;
  logic [7:0] grey;
  logic       s1_valid;
  logic [7:0] s1_grey;
  logic       s1_frame_start;
  logic       s1_fire;
  logic       has_result;
  result_t    result;
  result_t    out_reg;

  // Configuration registers with their documented reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_threshold <= 8'd235;
      cfg.frame_width     <= 13'd640;
      cfg.frame_height    <= 13'd480;
      cfg.col_start       <= 12'd320;
      cfg.col_end         <= 13'd640;
      cfg.row_start       <= 12'd0;
      cfg.row_end         <= 13'd480;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_LEVEL_THRESHOLD: cfg.level_threshold <= cfg_data[7:0];
        REG_FRAME_WIDTH:     cfg.frame_width     <= cfg_data;
        REG_FRAME_HEIGHT:    cfg.frame_height    <= cfg_data;
        REG_COL_START:       cfg.col_start       <= cfg_data[11:0];
        REG_COL_END:         cfg.col_end         <= cfg_data;
        REG_ROW_START:       cfg.row_start       <= cfg_data[11:0];
        REG_ROW_END:         cfg.row_end         <= cfg_data;
        default: ;
      endcase
    end
  end

  // The second stage may advance when the result register is free or is
  // being emptied in this cycle, even if this pixel yields no result.
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  llpf_grey u_grey (
    .red             (red),
    .green           (green),
    .blue            (blue),
    .level_threshold (cfg.level_threshold),
    .grey            (grey)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_grey        <= grey;
      s1_frame_start <= frame_start;
    end
  end

  llpf_tracker u_tracker (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_fire),
    .grey        (s1_grey),
    .frame_start (s1_frame_start),
    .cfg         (cfg),
    .has_result  (has_result),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      out_reg <= result;
    end
  end

  assign row_index   = out_reg.row_index;
  assign peak_column = out_reg.peak_column;
  assign peak_level  = out_reg.peak_level;
  assign frame_done  = out_reg.frame_done;

endmodule

[rtl/core/llpf_checker.sv]
// Port-level checker of the laser line row peak finder and its bind.
`include "laser_line_row_peak_finder_top_assert.svh"

module llpf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] row_index,
  input logic [11:0] peak_column,
  input logic [7:0]  peak_level,
  input logic        frame_done
);

  logic [32:0] out_payload;

  assign out_payload = {row_index, peak_column, peak_level, frame_done};

  // A stalled result stays offered.
  `LLPF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A stalled result keeps its payload.
  `LLPF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_payload))

  // With the receiver ready the pipeline never holds off the source.
  `LLPF_ASSERT_NOW(a_ready_flow, out_ready, in_ready)

  // Reset empties the result register.
  `LLPF_ASSERT_AFTER_RESET(a_reset_empty, !out_valid)

endmodule

bind laser_line_row_peak_finder_top llpf_checker u_llpf_checker (.*);

[tb/laser_line_row_peak_finder_top_tb.sv]
// Self-checking testbench for the laser line row peak finder: random and directed pixel frames.
module laser_line_row_peak_finder_top_tb;
  import llpf_pkg::*;

  // The run is far shorter than this; hitting it means the block hung.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Pipeline depth is two registers; the spare wait lets a pixel with no
  // row result clear the block before the registers change.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Length of the one long receiver stall that backs the pipeline up.
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned RANDOM_ITEMS = 150;
  // The block ignores writes to the one index that maps to no register.
  localparam logic [2:0] UNUSED_REG = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  blue = '0;
  logic [7:0]  green = '0;
  logic [7:0]  red = '0;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] row_index;
  logic [11:0] peak_column;
  logic [7:0]  peak_level;
  logic        frame_done;

  laser_line_row_peak_finder_top u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .blue        (blue),
    .green       (green),
    .red         (red),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .row_index   (row_index),
    .peak_column (peak_column),
    .peak_level  (peak_level),
    .frame_done  (frame_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register image as the block should hold it, starting from its reset values.
  cfg_t shadow = '{level_threshold: 8'd235, frame_width: 13'd640, frame_height: 13'd480,
                   col_start: 12'd320, col_end: 13'd640, row_start: 12'd0,
                   row_end: 13'd480};

  // Tracking state of the peak search, mirrored at the block's widths.
  logic [11:0] column_pos = '0;
  logic [11:0] row_pos = '0;
  logic [7:0]  best_lvl = '0;
  logic [11:0] best_col = '0;
  logic [12:0] tie_count = '0;
  bit          start_seen = 1'b0;

  pixel_t      pixels_to_send[$];
  result_t     pending_rows[$];
  int unsigned pixels_queued = 0;
  int unsigned pixels_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Idling switches per side, and the request for the long receiver stall.
  bit send_idle_on = 1'b0;
  bit recv_idle_on = 1'b0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;

  pixel_t      offered;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;

  function automatic int unsigned dim_limit(logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned keep_level(logic [7:0] c);
    return (c > shadow.level_threshold) ? c : 0;
  endfunction

  function automatic int unsigned draw_wait(bit on);
    return on ? $urandom_range(0, 8) : 0;
  endfunction

  // Coarse values land on zero, the threshold edges and full scale, which gives
  // plenty of ties in the window; otherwise any value is possible.
  function automatic logic [7:0] pick_channel(bit coarse);
    if (!coarse) return 8'($urandom);
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return shadow.level_threshold;
      2: return shadow.level_threshold + 8'd1;
      default: return 8'd255;
    endcase
  endfunction

  // Advances the peak search by one pixel and files the row result, if the
  // pixel closes a reported row.
  task automatic track_pixel(pixel_t px);
    int unsigned r, g, b, grey, fw, fh, col, row, last_row, column;
    logic [7:0] level;
    result_t res;
    r = keep_level(px.red);
    g = keep_level(px.green);
    b = keep_level(px.blue);
    grey = (r * W_RED + g * W_GREEN + b * W_BLUE + GREY_ROUND) >> GREY_SHIFT;
    fw = dim_limit(shadow.frame_width);
    fh = dim_limit(shadow.frame_height);
    if (px.frame_start) begin
      column_pos = '0;
      row_pos = '0;
      start_seen = 1'b0;
      best_lvl = '0;
      best_col = '0;
      tie_count = '0;
    end
    col = column_pos;
    row = row_pos;

    if (col == shadow.col_start && col < shadow.col_end) begin
      start_seen = 1'b1;
      best_col = 12'(col);
      best_lvl = 8'(grey);
      tie_count = 13'd1;
    end else if (start_seen && col > shadow.col_start && col < shadow.col_end) begin
      if (grey == best_lvl) begin
        if (tie_count < COUNT_MAX) tie_count = tie_count + 13'd1;
      end else if (grey > best_lvl) begin
        best_col = 12'(col);
        best_lvl = 8'(grey);
        tie_count = '0;
      end
    end

    if (col >= fw - 1) begin
      last_row = (shadow.row_end < fh) ? shadow.row_end : fh;
      if (row >= shadow.row_start && row < last_row) begin
        if (start_seen) begin
          column = best_col + (tie_count >> 1);
          level = best_lvl;
        end else begin
          column = shadow.col_start;
          level = '0;
        end
        if (column > COLUMN_MAX) column = COLUMN_MAX;
        res.row_index = 12'(row);
        res.peak_column = 12'(column);
        res.peak_level = level;
        res.frame_done = (row == last_row - 1);
        pending_rows = {pending_rows, res};
      end
      start_seen = 1'b0;
      best_lvl = '0;
      best_col = '0;
      tie_count = '0;
      column_pos = '0;
      row_pos = (row >= fh - 1) ? 12'd0 : 12'(row + 1);
    end else begin
      column_pos = 12'(col + 1);
    end
  endtask

  // Sender: offers one pixel per transaction, waiting a drawn number of
  // cycles after each accepted one. A held pixel never changes.
  always @(posedge clk) begin
    bit take;
    take = in_valid && in_ready;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (take) begin
        track_pixel(offered);
        pixels_accepted++;
        send_wait = draw_wait(send_idle_on);
      end
      if (!in_valid || take) begin
        if (send_wait == 0 && pixels_to_send.size() != 0) begin
          offered = pixels_to_send.pop_front();
          in_valid <= 1'b1;
          red <= offered.red;
          green <= offered.green;
          blue <= offered.blue;
          frame_start <= offered.frame_start;
        end else begin
          in_valid <= 1'b0;
          if (send_wait != 0) send_wait--;
        end
      end
    end
  end

  // Receiver: after each result transaction it drops ready for a drawn
  // number of cycles. Once per run it stalls for a long stretch instead,
  // so the pipeline fills and in_ready falls while pixels keep coming.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) recv_wait = draw_wait(recv_idle_on);
      if (hold_armed && !hold_done) begin
        recv_wait = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (recv_wait == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        recv_wait--;
      end
    end
  end

  // Checker: every result transaction is matched against the oldest
  // predicted row, one field at a time.
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        $error("unexpected row result: row_index %0d peak_column %0d", row_index, peak_column);
        mismatches++;
      end else begin
        want = pending_rows.pop_front();
        if (row_index !== want.row_index) begin
          $error("row_index mismatch: expected %0d, actual %0d", want.row_index, row_index);
          mismatches++;
        end
        if (peak_column !== want.peak_column) begin
          $error("peak_column mismatch: expected %0d, actual %0d",
                 want.peak_column, peak_column);
          mismatches++;
        end
        if (peak_level !== want.peak_level) begin
          $error("peak_level mismatch: expected %0d, actual %0d", want.peak_level, peak_level);
          mismatches++;
        end
        if (frame_done !== want.frame_done) begin
          $error("frame_done mismatch: expected %0b, actual %0b", want.frame_done, frame_done);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("laser_line_row_peak_finder_top_tb failed");
    $finish;
  end

  // One register write per clock; the shadow copy follows the block's masking.
  task automatic write_register(logic [2:0] index, logic [12:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    case (index)
      REG_LEVEL_THRESHOLD: shadow.level_threshold = data[7:0];
      REG_FRAME_WIDTH:     shadow.frame_width = data;
      REG_FRAME_HEIGHT:    shadow.frame_height = data;
      REG_COL_START:       shadow.col_start = data[11:0];
      REG_COL_END:         shadow.col_end = data;
      REG_ROW_START:       shadow.row_start = data[11:0];
      REG_ROW_END:         shadow.row_end = data;
      default: ;
    endcase
  endtask

  // Writes all seven registers. Bits above a register's width carry noise,
  // since the block is expected to drop them.
  task automatic load_window(logic [7:0] thr, logic [12:0] fw, logic [12:0] fh,
                             logic [11:0] cs, logic [12:0] ce, logic [11:0] rs,
                             logic [12:0] re);
    write_register(REG_LEVEL_THRESHOLD, {5'($urandom), thr});
    write_register(REG_FRAME_WIDTH, fw);
    write_register(REG_FRAME_HEIGHT, fh);
    write_register(REG_COL_START, {1'($urandom), cs});
    write_register(REG_COL_END, ce);
    write_register(REG_ROW_START, {1'($urandom), rs});
    write_register(REG_ROW_END, re);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_one(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
    pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.frame_start = fs;
    pixels_to_send = {pixels_to_send, px};
    pixels_queued++;
  endtask

  // Raster-order frames for the current geometry. Most frames open with a
  // start mark; with noise on, a stray mark now and then breaks a row.
  task automatic queue_pixels(int unsigned count, bit coarse, bit noisy);
    int unsigned fw, fh, gcol, grow;
    logic fs;
    fw = dim_limit(shadow.frame_width);
    fh = dim_limit(shadow.frame_height);
    gcol = 0;
    grow = 0;
    for (int unsigned i = 0; i < count; i++) begin
      fs = (i == 0) || (gcol == 0 && grow == 0 && $urandom_range(0, 19) != 0);
      if (noisy && $urandom_range(0, 49) == 0) fs = 1'b1;
      if (fs) begin
        gcol = 0;
        grow = 0;
      end
      queue_one(pick_channel(coarse), pick_channel(coarse), pick_channel(coarse), fs);
      gcol++;
      if (gcol >= fw) begin
        gcol = 0;
        grow = (grow + 1 >= fh) ? 0 : grow + 1;
      end
    end
  endtask

  // Waits until every pixel has been taken and every row result checked,
  // then lets the pipeline drain pixels that produce no result.
  task automatic wait_until_quiet();
    while (pixels_accepted != pixels_queued || pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned random_items, n;
    logic [12:0] fw_pick, fh_pick, ce_pick, re_pick;
    logic [11:0] cs_pick, rs_pick;
    logic [7:0]  thr_pick;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset values: one 640-pixel row searched from column 320.
    queue_pixels(640, 1'b1, 1'b0);
    wait_until_quiet();

    // Directed frame: 6 x 3 with the window on columns 1..4 and rows 1..2.
    // The write to the unused index must leave every register alone.
    write_register(UNUSED_REG, 13'($urandom));
    load_window(8'd100, 13'd6, 13'd3, 12'd1, 13'd5, 12'd1, 13'd3);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    // Row 0 is outside the row window.
    queue_one(8'd0, 8'd0, 8'd0, 1'b1);
    queue_one(8'd255, 8'd255, 8'd255, 1'b0);
    queue_one(8'd255, 8'd0, 8'd0, 1'b0);
    queue_one(8'd0, 8'd255, 8'd0, 1'b0);
    queue_one(8'd0, 8'd0, 8'd255, 1'b0);
    queue_one(8'd100, 8'd100, 8'd100, 1'b0);
    // Row 1: a channel at the threshold is dropped, one just above is kept;
    // a brighter pixel restarts the tie count and a later equal one bumps it.
    // Bright pixels outside the window must be ignored.
    queue_one(8'd255, 8'd255, 8'd255, 1'b0);
    queue_one(8'd100, 8'd100, 8'd100, 1'b0);
    queue_one(8'd101, 8'd0, 8'd0, 1'b0);
    queue_one(8'd0, 8'd0, 8'd101, 1'b0);
    queue_one(8'd101, 8'd0, 8'd0, 1'b0);
    queue_one(8'd255, 8'd255, 8'd255, 1'b0);
    // Row 2, the last reported row: the whole window is at full scale.
    queue_one(8'd0, 8'd0, 8'd0, 1'b0);
    queue_one(8'd255, 8'd255, 8'd255, 1'b0);
    queue_one(8'd255, 8'd255, 8'd255, 1'b0);
    queue_one(8'd255, 8'd255, 8'd255, 1'b0);
    queue_one(8'd255, 8'd255, 8'd255, 1'b0);
    queue_one(8'd101, 8'd101, 8'd101, 1'b0);
    // A stray pixel, then a start mark that resynchronizes mid-row.
    queue_one(8'd50, 8'd50, 8'd50, 1'b0);
    queue_one(8'd200, 8'd200, 8'd200, 1'b1);
    queue_one(8'd255, 8'd101, 8'd0, 1'b0);
    queue_one(8'd101, 8'd255, 8'd0, 1'b0);
    queue_one(8'd0, 8'd101, 8'd255, 1'b0);
    queue_one(8'd255, 8'd255, 8'd0, 1'b0);
    queue_one(8'd1, 8'd2, 8'd3, 1'b0);
    wait_until_quiet();

    // Zero width and height act as one, so every pixel is a whole frame;
    // an empty column window reports the start column at level zero.
    load_window(8'd0, 13'd0, 13'd0, 12'd0, 13'd0, 12'd0, 13'd1);
    queue_pixels(20, 1'b0, 1'b0);
    wait_until_quiet();

    // An empty row window: pixels flow but no row is ever reported.
    load_window(8'd255, 13'd3, 13'd2, 12'd5, 13'd8, 12'd0, 13'd0);
    queue_pixels(12, 1'b1, 1'b1);
    wait_until_quiet();

    // Back-pressure: short rows give a result every other pixel while the
    // receiver stalls for a long stretch.
    load_window(8'd60, 13'd2, 13'd4, 12'd0, 13'd2, 12'd0, 13'd4);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b1;
    queue_pixels(200, 1'b1, 1'b0);
    hold_armed = 1'b1;
    wait_until_quiet();

    // An oversized width acts as 4096, so a short burst never closes a row
    // and nothing is reported.
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    load_window(8'd128, 13'd8191, 13'd2, 12'd10, 13'd8191, 12'd0, 13'd1);
    queue_pixels(30, 1'b0, 1'b0);
    wait_until_quiet();

    // An oversized height acts as 4096 with one-pixel rows; rows 20 to 24
    // are reported and the last of them closes the frame.
    load_window(8'd20, 13'd1, 13'd8191, 12'd0, 13'd1, 12'd20, 13'd25);
    queue_pixels(30, 1'b1, 1'b0);
    wait_until_quiet();

    // Random geometries, mostly small, with random idling on each side.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      fw_pick = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 40))
                                            : 13'($urandom_range(1, 10));
      fh_pick = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 8191))
                                            : 13'($urandom_range(1, 6));
      cs_pick = 12'($urandom_range(0, fw_pick + 2));
      ce_pick = ($urandom_range(0, 5) == 0) ? 13'($urandom_range(0, cs_pick))
                                            : 13'($urandom_range(cs_pick, fw_pick + 3));
      rs_pick = 12'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0: re_pick = 13'd0;
        1: re_pick = 13'd8191;
        default: re_pick = 13'($urandom_range(rs_pick, rs_pick + 6));
      endcase
      case ($urandom_range(0, 5))
        0: thr_pick = 8'd0;
        1: thr_pick = 8'd255;
        default: thr_pick = 8'($urandom_range(0, 200));
      endcase
      load_window(thr_pick, fw_pick, fh_pick, cs_pick, ce_pick, rs_pick, re_pick);
      send_idle_on = ($urandom_range(0, 2) != 0);
      recv_idle_on = ($urandom_range(0, 2) != 0);
      n = $urandom_range(20, 90);
      queue_pixels(n, 1'($urandom_range(0, 1)), 1'b1);
      random_items += n;
      wait_until_quiet();
    end

    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("laser_line_row_peak_finder_top_tb passed");
    end else begin
      if (pending_rows.size() != 0) $error("%0d row results never arrived", pending_rows.size());
      $display("laser_line_row_peak_finder_top_tb failed");
    end
    $finish;
  end

endmodule
